// ===== sv/fbmc_pkg.sv =====
// shared types and constants of the frequency band mask check
package fbmc_pkg;

  // field widths fixed by the interface
  localparam int unsigned ACTION_W     = 1;
  localparam int unsigned BAND_INDEX_W = 6;
  localparam int unsigned BAND_COUNT_W = 7;

  // default sizing
  localparam int unsigned MAX_BANDS_DEF = 64;
  localparam int unsigned FREQ_BITS_DEF = 40;

  // action codes
  localparam logic [ACTION_W-1:0] ACTION_LOAD  = 1'b0;
  localparam logic [ACTION_W-1:0] ACTION_QUERY = 1'b1;

  // control part of the query token that walks the cell chain
  typedef struct packed {
    logic valid;
    logic done;
    logic masked;
  } tok_t;

endpackage

// ===== sv/fbmc_cell.sv =====
// one band slot of the chain: holds the band edges and checks a passing query
module fbmc_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned EDGE_W   = fbmc_pkg::FREQ_BITS_DEF + 3
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_en_i,
  input  logic [fbmc_pkg::BAND_INDEX_W-1:0]  band_index_i,
  input  logic signed [EDGE_W-1:0]           band_lo_i,
  input  logic signed [EDGE_W-1:0]           band_hi_i,
  input  logic [fbmc_pkg::BAND_COUNT_W-1:0]  band_count_i,
  input  fbmc_pkg::tok_t                     tok_i,
  input  logic signed [EDGE_W-1:0]           sig_lo_i,
  input  logic signed [EDGE_W-1:0]           sig_hi_i,
  output fbmc_pkg::tok_t                     tok_o,
  output logic signed [EDGE_W-1:0]           sig_lo_o,
  output logic signed [EDGE_W-1:0]           sig_hi_o
);
  import fbmc_pkg::*;

  logic signed [EDGE_W-1:0] band_lo_q;
  logic signed [EDGE_W-1:0] band_hi_q;
  logic signed [EDGE_W-1:0] sig_lo_q;
  logic signed [EDGE_W-1:0] sig_hi_q;
  tok_t                     tok_q;
  tok_t                     tok_d;
  logic                     load_hit;
  logic                     active;

  // slot select and participation of this cell
  assign load_hit = load_en_i && (int'(band_index_i) == CELL_IDX);
  assign active   = int'(band_count_i) > CELL_IDX;

  // stored band edges
  always_ff @(posedge clk_i) begin
    if (load_hit) begin
      band_lo_q <= band_lo_i;
      band_hi_q <= band_hi_i;
    end
  end

  // compare the passing query against this band
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.done && active) begin
      if (sig_hi_i < band_lo_q) begin
        tok_d.done   = 1'b1;
        tok_d.masked = 1'b0;
      end else if (sig_lo_i <= band_hi_q) begin
        tok_d.done   = 1'b1;
        tok_d.masked = 1'b1;
      end
    end
  end

  // hand the token to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // query edges travel alongside
  always_ff @(posedge clk_i) begin
    sig_lo_q <= sig_lo_i;
    sig_hi_q <= sig_hi_i;
  end

  assign tok_o    = tok_q;
  assign sig_lo_o = sig_lo_q;
  assign sig_hi_o = sig_hi_q;

endmodule

// ===== sv/frequency_band_mask_check_core.sv =====
// top level of the frequency band mask check: a chain of band cells
// usage:
//   an item transfers at a rising edge with start high and busy low.
//   action load writes one band (center, width) into slot band_index
//   and gives no result; busy stays low, so loads can follow every
//   cycle. a load to a slot at or beyond MAX_BANDS is dropped.
//   action query sends a token down a row of MAX_BANDS cells, one cell
//   per cycle; each cell holds one band and checks the token against it.
//   the result appears on masked_o with masked_valid_o high for exactly
//   one cycle, when the token reaches the end of the chain; busy is still
//   high in that cycle and drops in the next, so the next item can
//   transfer in the cycle after the strobe; no new item is taken while
//   a query is in the chain. band_count is written through cfg_valid_i /
//   cfg_ready_o / cfg_data_i by the user only while the block is idle;
//   the block does not enforce this. only the first band_count cells
//   take part. the receiver cannot stall; masked_o is valid only with
//   the strobe. reset clears band_count and the chain tokens; band
//   contents stay undefined until loaded.
module frequency_band_mask_check_core #(
  parameter int unsigned MAX_BANDS = fbmc_pkg::MAX_BANDS_DEF,
  parameter int unsigned FREQ_BITS = fbmc_pkg::FREQ_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [fbmc_pkg::ACTION_W-1:0]      action_i,
  input  logic [fbmc_pkg::BAND_INDEX_W-1:0]  band_index_i,
  input  logic [FREQ_BITS-1:0]               band_center_i,
  input  logic [FREQ_BITS-1:0]               band_width_i,
  input  logic [FREQ_BITS-1:0]               query_freq_i,
  input  logic [FREQ_BITS-1:0]               query_width_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fbmc_pkg::BAND_COUNT_W-1:0]  cfg_data_i,
  output logic                               masked_valid_o,
  output logic                               masked_o
);
  import fbmc_pkg::*;

  localparam int unsigned EDGE_W = FREQ_BITS + 3;

  logic                      busy_q;
  logic                      busy_d;
  logic [BAND_COUNT_W-1:0]   band_count_q;
  logic                      item_xfer;
  logic                      load_en;
  logic                      query_en;
  logic signed [EDGE_W-1:0]  band_lo;
  logic signed [EDGE_W-1:0]  band_hi;
  logic signed [EDGE_W-1:0]  sig_lo;
  logic signed [EDGE_W-1:0]  sig_hi;
  tok_t                      tok_chain [MAX_BANDS+1];
  logic signed [EDGE_W-1:0]  lo_chain  [MAX_BANDS+1];
  logic signed [EDGE_W-1:0]  hi_chain  [MAX_BANDS+1];

  // item transfer decode
  assign item_xfer = start && !busy_q;
  assign load_en   = item_xfer && (action_i == ACTION_LOAD);
  assign query_en  = item_xfer && (action_i == ACTION_QUERY);

  // doubled edges: 2c -/+ w, signed, never wrapping
  assign band_lo = $signed({2'b00, band_center_i, 1'b0}) - $signed({3'b000, band_width_i});
  assign band_hi = $signed({2'b00, band_center_i, 1'b0}) + $signed({3'b000, band_width_i});
  assign sig_lo  = $signed({2'b00, query_freq_i, 1'b0}) - $signed({3'b000, query_width_i});
  assign sig_hi  = $signed({2'b00, query_freq_i, 1'b0}) + $signed({3'b000, query_width_i});

  // token entering the chain
  always_comb begin
    tok_chain[0]        = '0;
    tok_chain[0].valid  = query_en;
  end
  assign lo_chain[0] = sig_lo;
  assign hi_chain[0] = sig_hi;

  // row of band cells
  for (genvar k = 0; k < MAX_BANDS; k++) begin : g_cell
    fbmc_cell #(
      .CELL_IDX (k),
      .EDGE_W   (EDGE_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .load_en_i    (load_en),
      .band_index_i (band_index_i),
      .band_lo_i    (band_lo),
      .band_hi_i    (band_hi),
      .band_count_i (band_count_q),
      .tok_i        (tok_chain[k]),
      .sig_lo_i     (lo_chain[k]),
      .sig_hi_i     (hi_chain[k]),
      .tok_o        (tok_chain[k+1]),
      .sig_lo_o     (lo_chain[k+1]),
      .sig_hi_o     (hi_chain[k+1])
    );
  end

  // busy from query transfer until the token leaves the last cell
  always_comb begin
    busy_d = busy_q;
    if (query_en) begin
      busy_d = 1'b1;
    end else if (tok_chain[MAX_BANDS].valid) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // band count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      band_count_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign busy           = busy_q;
  assign masked_valid_o = tok_chain[MAX_BANDS].valid;
  assign masked_o       = tok_chain[MAX_BANDS].masked;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// testbench of the frequency band mask check: directed and random band tables and queries
module tb;
  import fbmc_pkg::*;

  localparam int unsigned NBANDS       = MAX_BANDS_DEF;
  localparam int unsigned FW           = FREQ_BITS_DEF;
  localparam longint      FREQ_MAX     = (longint'(1) << FW) - 1;
  localparam int          RANDOM_ITEMS = 1650;
  localparam int          CYCLE_LIMIT  = 1500000;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [ACTION_W-1:0]     action_i;
  logic [BAND_INDEX_W-1:0] band_index_i;
  logic [FW-1:0]           band_center_i;
  logic [FW-1:0]           band_width_i;
  logic [FW-1:0]           query_freq_i;
  logic [FW-1:0]           query_width_i;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [BAND_COUNT_W-1:0] cfg_data_i;
  logic                    masked_valid_o;
  logic                    masked_o;

  frequency_band_mask_check_core #(
    .MAX_BANDS(NBANDS),
    .FREQ_BITS(FW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .band_index_i  (band_index_i),
    .band_center_i (band_center_i),
    .band_width_i  (band_width_i),
    .query_freq_i  (query_freq_i),
    .query_width_i (query_width_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .masked_valid_o(masked_valid_o),
    .masked_o      (masked_o)
  );

  // shadow copy of the band table and the count register
  logic [FW-1:0]           center_tab [NBANDS];
  logic [FW-1:0]           width_tab  [NBANDS];
  logic [BAND_COUNT_W-1:0] band_count_q;

  logic pending_masked [$];
  logic want_masked;
  int   error_count;
  int   cycle_count;
  int   items_sent;
  int   quiet_run;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // compare each result strobe with the oldest pending query
  always @(posedge clk_i) begin
    if (rst_ni && masked_valid_o === 1'b1) begin
      if (pending_masked.size() == 0) begin
        $error("masked: expected none, actual %0d", masked_o);
        error_count++;
      end else begin
        want_masked = pending_masked.pop_front();
        if (masked_o !== want_masked) begin
          $error("masked: expected %0d, actual %0d", want_masked, masked_o);
          error_count++;
        end
      end
    end
  end

  // walk the examined bands in order, edges doubled so no halving is needed
  function automatic logic predict_masked(input logic [FW-1:0] sig_f,
                                          input logic [FW-1:0] sig_w);
    longint      sig_lo;
    longint      sig_hi;
    longint      band_lo;
    longint      band_hi;
    int unsigned walk;
    sig_lo = 2 * longint'(sig_f) - longint'(sig_w);
    sig_hi = 2 * longint'(sig_f) + longint'(sig_w);
    walk   = (band_count_q > NBANDS) ? NBANDS : band_count_q;
    for (int unsigned k = 0; k < walk; k++) begin
      band_lo = 2 * longint'(center_tab[k]) - longint'(width_tab[k]);
      band_hi = 2 * longint'(center_tab[k]) + longint'(width_tab[k]);
      if (sig_hi < band_lo) return 1'b0;
      if (sig_lo <= band_hi && sig_hi >= band_lo) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic longint rand_below(input longint n);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if (n <= 0) return 0;
    return longint'(r[61:0]) % n;
  endfunction

  function automatic logic [FW-1:0] rand_freq();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[FW-1:0];
  endfunction

  // full range value with the extremes weighted up
  function automatic logic [FW-1:0] pick_freq();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return FW'(rand_below(256));
      default: return rand_freq();
    endcase
  endfunction

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int pick_gap();
    int r;
    if (quiet_run > 0) begin
      quiet_run--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet_run = $urandom_range(20, 40);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // drive one item, hold it until it transfers, then record what it should do
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [BAND_INDEX_W-1:0] idx,
                           input logic [FW-1:0] bc, input logic [FW-1:0] bw,
                           input logic [FW-1:0] qf, input logic [FW-1:0] qw);
    int gap;
    @(negedge clk_i);
    action_i      = act;
    band_index_i  = idx;
    band_center_i = bc;
    band_width_i  = bw;
    query_freq_i  = qf;
    query_width_i = qw;
    start         = 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    items_sent++;
    if (act == ACTION_LOAD) begin
      if (idx < NBANDS) begin
        center_tab[idx] = bc;
        width_tab[idx]  = bw;
      end
    end else begin
      pending_masked.push_back(predict_masked(qf, qw));
    end
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_load(input int idx, input logic [FW-1:0] bc, input logic [FW-1:0] bw);
    send_item(ACTION_LOAD, BAND_INDEX_W'(idx), bc, bw, rand_freq(), rand_freq());
  endtask

  task automatic send_query(input logic [FW-1:0] qf, input logic [FW-1:0] qw);
    send_item(ACTION_QUERY, BAND_INDEX_W'($urandom), rand_freq(), rand_freq(), qf, qw);
  endtask

  // stop sending and let every pending query come back
  task automatic settle_idle();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_masked.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_band_count(input int value);
    settle_idle();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = BAND_COUNT_W'(value);
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    band_count_q = BAND_COUNT_W'(value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // bands sorted by center, loaded into slots 0..n-1 in shuffled order
  task automatic load_sorted_table(input int n, input longint step);
    logic [FW-1:0] cs [NBANDS];
    logic [FW-1:0] ws [NBANDS];
    int            order [NBANDS];
    longint        c;
    int            j;
    int            t;
    c = rand_below(FREQ_MAX - NBANDS * (step + 1));
    for (int k = 0; k < n; k++) begin
      c     = c + 1 + rand_below(step);
      cs[k] = FW'(c);
      ws[k] = ($urandom_range(0, 9) == 0) ? '0 : FW'(rand_below(2 * step + 1));
      // a wide first band may push its low edge below zero
      if (k == 0 && $urandom_range(0, 5) == 0) ws[k] = rand_freq();
      order[k] = k;
    end
    for (int k = n - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      t        = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    for (int k = 0; k < n; k++) send_load(order[k], cs[order[k]], ws[order[k]]);
  endtask

  task automatic load_random_table(input int n);
    for (int k = 0; k < n; k++) send_load(k, pick_freq(), pick_freq());
  endtask

  // query whose low or high edge lands on or just past an edge of a loaded band, or near the band
  task automatic query_at_band(input int n, input longint step);
    int     k;
    longint lo;
    longint hi;
    longint tgt;
    longint qw;
    longint qf;
    bit     on_high;
    k  = $urandom_range(0, n - 1);
    lo = 2 * longint'(center_tab[k]) - longint'(width_tab[k]);
    hi = 2 * longint'(center_tab[k]) + longint'(width_tab[k]);
    qw = ($urandom_range(0, 7) == 0) ? 0 : rand_below(2 * step + 1);
    on_high = 1'b0;
    case ($urandom_range(0, 4))
      0: begin tgt = lo;     on_high = 1'b1; end
      1: begin tgt = lo - 1; on_high = 1'b1; end
      2: tgt = hi;
      3: tgt = hi + 1;
      default: begin
        tgt     = lo + rand_below(hi - lo + 2 * step + 1) - step;
        on_high = $urandom_range(0, 1);
      end
    endcase
    if (on_high) begin
      if (tgt - qw < 0) qw = tgt;
      if ((tgt - qw) % 2 != 0) qw = qw + 1;
      qf = (tgt - qw) / 2;
    end else begin
      if (tgt + qw < 0) qw = -tgt;
      if ((tgt + qw) % 2 != 0) qw = qw + 1;
      qf = (tgt + qw) / 2;
    end
    if (qw < 0 || qw > FREQ_MAX || qf < 0 || qf > FREQ_MAX) begin
      qf = longint'(rand_freq());
      qw = longint'(rand_freq());
    end
    send_query(FW'(qf), FW'(qw));
  endtask

  // count left at reset, then written as zero: no band is examined
  task automatic test_zero_count();
    send_query('0, '0);
    send_query('1, '1);
    set_band_count(0);
    send_query(FW'(12345), '1);
  endtask

  // four hand-placed bands: negative low edge, touching edges, top of range
  task automatic test_small_table_edges();
    localparam longint HALF = longint'(1) << (FW - 1);
    send_load(0, FW'(5), FW'(20));
    send_load(1, FW'(HALF), '0);
    send_load(2, FW'(HALF + 10), FW'(4));
    send_load(3, '1, '1);
    set_band_count(4);
    send_query('0, '0);
    send_query('0, '1);
    send_query(FW'(15), '0);
    send_query(FW'(16), FW'(1));
    send_query(FW'(HALF - 1), FW'(2));
    send_query(FW'(HALF - 1), FW'(1));
    send_query(FW'(HALF + 12), '0);
    send_query(FW'(HALF + 13), FW'(1));
    send_query('1, '0);
    send_query('1, '1);
    // one band only: signal above it runs off the end of the walk
    set_band_count(1);
    send_query('1, '0);
    send_query(FW'(16), '0);
  endtask

  // counts at and beyond the table size examine every slot and no more
  task automatic test_count_beyond_table();
    load_sorted_table(NBANDS, longint'(1) << 20);
    set_band_count((1 << BAND_COUNT_W) - 1);
    send_query('1, '0);
    send_query(center_tab[NBANDS-1], '0);
    send_query('0, '0);
    set_band_count(NBANDS + 1);
    send_query('1, '0);
    send_query(center_tab[NBANDS/2], FW'(3));
    set_band_count(NBANDS);
    send_query('1, '0);
    send_query(center_tab[NBANDS-1], '1);
  endtask

  // phases of a freshly loaded table, a count and a burst of queries
  task automatic test_random_phases();
    int     first;
    int     n;
    int     count;
    int     r;
    bit     noisy;
    longint step;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      n = (r < 7) ? $urandom_range(1, 12) : (r < 9) ? $urandom_range(13, NBANDS - 1) : NBANDS;
      noisy = ($urandom_range(0, 6) == 0);
      step  = longint'(1) << $urandom_range(1, 33);
      if (noisy) load_random_table(n);
      else load_sorted_table(n, step);
      r = $urandom_range(0, 19);
      if (r == 0) count = 0;
      else if (r == 1 && n == NBANDS) count = $urandom_range(NBANDS, (1 << BAND_COUNT_W) - 1);
      else if (r < 5) count = $urandom_range(0, n);
      else count = n;
      set_band_count(count);
      repeat ($urandom_range(8, 30)) begin
        r = $urandom_range(0, 19);
        // a reload in the middle of a burst may break the table's order
        if (r == 0) send_load($urandom_range(0, n - 1), pick_freq(), pick_freq());
        else if (noisy || r < 4) send_query(pick_freq(), pick_freq());
        else query_at_band(n, step);
      end
    end
  endtask

  initial begin
    error_count   = 0;
    cycle_count   = 0;
    items_sent    = 0;
    quiet_run     = 0;
    band_count_q  = '0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    action_i      = ACTION_LOAD;
    band_index_i  = '0;
    band_center_i = '0;
    band_width_i  = '0;
    query_freq_i  = '0;
    query_width_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_zero_count();
    test_small_table_edges();
    test_count_beyond_table();
    test_random_phases();

    settle_idle();
    repeat (NBANDS + 4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
